### sv/rci_pkg.sv
// Shared types, widths and arithmetic steps for the ray / capped cylinder intersection block.
// No dependencies; every other file of the block imports this package.
package rci_pkg;

	localparam int FRAC_BITS = 16;
	localparam int W = 32;
	localparam int MAG_W = 2 * W;
	localparam int B_W = MAG_W + 2;
	localparam int SQ_W = 2 * MAG_W;
	localparam int ROOT_W = SQ_W / 2;
	localparam int SREM_W = ROOT_W + 2;
	localparam int QW = W + 1;
	localparam int SNUM_W = MAG_W + 1;
	localparam int SV_W = SNUM_W + 2;
	localparam int NUM_W = SNUM_W + FRAC_BITS;
	localparam int TP_W = 2 * W;
	localparam int TM_W = TP_W - FRAC_BITS;
	localparam int PT_W = TM_W + 2;
	localparam int SQR_W = 2 * FRAC_BITS + 3;
	localparam int CFG_AW = 2;
	localparam int TOL_W = 16;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FRONT_STAGES = 4;
	localparam int BACK_LAT = 3 + ROOT_W + 4 + QW + 4;

	typedef enum logic [CFG_AW-1:0] {
		REG_BOUND_LOW  = 2'd0,
		REG_BOUND_HIGH = 2'd1,
		REG_CAPPED     = 2'd2,
		REG_TOL        = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [W-1:0] origin_x;
		logic signed [W-1:0] origin_y;
		logic signed [W-1:0] origin_z;
		logic signed [W-1:0] dir_x;
		logic signed [W-1:0] dir_y;
		logic signed [W-1:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic [2:0]          hit_count;
		logic signed [W-1:0] hit_first;
		logic signed [W-1:0] hit_second;
		logic signed [W-1:0] hit_third;
		logic signed [W-1:0] hit_fourth;
	} hit_t;

	typedef struct packed {
		logic [W-1:0]     bound_low;
		logic [W-1:0]     bound_high;
		logic             capped;
		logic [TOL_W-1:0] tol;
	} cfg_t;

	// front to back: ray plus the side quadratic in sign/magnitude form
	typedef struct packed {
		ray_t             ray;
		logic [MAG_W-1:0] am;
		logic             a_ok;
		logic             b_neg;
		logic [MAG_W-1:0] bm;
		logic             c_neg;
		logic [MAG_W-1:0] cm;
		logic             cap_en;
	} job_t;

	typedef struct packed {
		logic [MAG_W-1:0] rem;
		logic [QW-1:0]    q;
	} div_st_t;

	typedef struct packed {
		logic [SREM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} sq_st_t;

	function automatic logic [W-1:0] mag32(logic [W-1:0] v);
		return v[W-1] ? W'(W'(0) - v) : v;
	endfunction

	// one restoring division step
	function automatic div_st_t div_step(div_st_t s, logic [MAG_W-1:0] den, logic nbit);
		logic [MAG_W:0] t;
		div_st_t r;
		t = {s.rem, nbit};
		r.q = {s.q[QW-2:0], 1'b0};
		r.rem = t[MAG_W-1:0];
		if (t >= {1'b0, den}) begin
			r.rem = MAG_W'(t - {1'b0, den});
			r.q[0] = 1'b1;
		end
		return r;
	endfunction

	// one digit of the integer square root, two radicand bits in
	function automatic sq_st_t sqrt_step(sq_st_t s, logic [1:0] two);
		logic [SREM_W+1:0] r2;
		logic [SREM_W+1:0] trial;
		sq_st_t r;
		r2 = {s.rem, two};
		trial = {2'b00, s.root, 2'b01};
		r.root = {s.root[ROOT_W-2:0], 1'b0};
		r.rem = r2[SREM_W-1:0];
		if (r2 >= trial) begin
			r.rem = SREM_W'(r2 - trial);
			r.root[0] = 1'b1;
		end
		return r;
	endfunction

	// saturate a sign/magnitude quotient to the signed 32-bit range
	function automatic logic [W-1:0] sat_q(logic neg, logic ovf, logic [QW-1:0] q);
		logic [W-1:0] r;
		if (!neg) begin
			r = (ovf || q > {2'b00, {(W-1){1'b1}}}) ? {1'b0, {(W-1){1'b1}}} : q[W-1:0];
		end else begin
			r = (ovf || q > {2'b01, {(W-1){1'b0}}}) ? {1'b1, {(W-1){1'b0}}} :
				W'(W'(0) - q[W-1:0]);
		end
		return r;
	endfunction

endpackage

### sv/rci_front.sv
// Front end: registers a ray, forms the side quadratic terms and the cap/side enables.
// Depends on rci_pkg; feeds rci_fifo.
module rci_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  rci_pkg::ray_t ray,
	input  rci_pkg::cfg_t cfg,
	output logic          push,
	output rci_pkg::job_t job
);
	import rci_pkg::*;

	logic [FRONT_STAGES-1:0] vld_s;

	ray_t         ray_s1, ray_s2, ray_s3, ray_s4;
	logic [W-1:0] mox_s1, moz_s1, mdx_s1, mdz_s1, mdy_s1;
	logic [MAG_W-1:0] pdx_s2, pdz_s2, pbx_s2, pbz_s2, pcx_s2, pcz_s2;
	logic             cap_en_s2, cap_en_s3, cap_en_s4;
	logic [MAG_W-1:0] a_s3, a_s4;
	logic [B_W-1:0]   b_s3, c_s3;
	logic             a_ok_s3, a_ok_s4;
	logic             b_neg_s4, c_neg_s4;
	logic [MAG_W-1:0] bm_s4, cm_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[FRONT_STAGES-2:0], take};
		end
	end

	always_ff @(posedge clk) begin
		ray_s1 <= ray;
		mox_s1 <= mag32(ray.origin_x);
		moz_s1 <= mag32(ray.origin_z);
		mdx_s1 <= mag32(ray.dir_x);
		mdz_s1 <= mag32(ray.dir_z);
		mdy_s1 <= mag32(ray.dir_y);

		ray_s2 <= ray_s1;
		pdx_s2 <= MAG_W'(mdx_s1) * MAG_W'(mdx_s1);
		pdz_s2 <= MAG_W'(mdz_s1) * MAG_W'(mdz_s1);
		pbx_s2 <= MAG_W'(mox_s1) * MAG_W'(mdx_s1);
		pbz_s2 <= MAG_W'(moz_s1) * MAG_W'(mdz_s1);
		pcx_s2 <= MAG_W'(mox_s1) * MAG_W'(mox_s1);
		pcz_s2 <= MAG_W'(moz_s1) * MAG_W'(moz_s1);
		cap_en_s2 <= cfg.capped && !(mdy_s1 == '0 || mdy_s1 < W'(cfg.tol));

		ray_s3 <= ray_s2;
		cap_en_s3 <= cap_en_s2;
		a_s3 <= pdx_s2 + pdz_s2;
		b_s3 <= ((ray_s2.origin_x[W-1] ^ ray_s2.dir_x[W-1]) ?
				B_W'(B_W'(0) - B_W'(pbx_s2)) : B_W'(pbx_s2)) +
			((ray_s2.origin_z[W-1] ^ ray_s2.dir_z[W-1]) ?
				B_W'(B_W'(0) - B_W'(pbz_s2)) : B_W'(pbz_s2));
		c_s3 <= B_W'(pcx_s2) + B_W'(pcz_s2) - (B_W'(1) << (2 * FRAC_BITS));
		a_ok_s3 <= !((pdx_s2 + pdz_s2) == '0 ||
			(pdx_s2 + pdz_s2) < (MAG_W'(cfg.tol) << FRAC_BITS));

		ray_s4 <= ray_s3;
		cap_en_s4 <= cap_en_s3;
		a_s4 <= a_s3;
		a_ok_s4 <= a_ok_s3;
		b_neg_s4 <= b_s3[B_W-1];
		bm_s4 <= b_s3[B_W-1] ? MAG_W'(B_W'(0) - b_s3) : b_s3[MAG_W-1:0];
		c_neg_s4 <= c_s3[B_W-1];
		cm_s4 <= c_s3[B_W-1] ? MAG_W'(B_W'(0) - c_s3) : c_s3[MAG_W-1:0];
	end

	assign push = vld_s[FRONT_STAGES-1];

	always_comb begin
		job.ray = ray_s4;
		job.am = a_s4;
		job.a_ok = a_ok_s4;
		job.b_neg = b_neg_s4;
		job.bm = bm_s4;
		job.c_neg = c_neg_s4;
		job.cm = cm_s4;
		job.cap_en = cap_en_s4;
	end

endmodule

### sv/rci_fifo.sv
// Short job queue between the front end and the back end, with a registered read port.
// Depends on rci_pkg (job_t, depth constants).
module rci_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rci_pkg::job_t        wdata,
	input  logic                 pop,
	output rci_pkg::job_t        rdata,
	output logic                 rvalid,
	output logic                 empty,
	output logic [rci_pkg::FIFO_AW:0] level
);
	import rci_pkg::*;

	job_t               mem_q [FIFO_DEPTH];
	job_t               rdata_q;
	logic               rvalid_q;
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
		if (pop) begin
			rdata_q <= mem_q[rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
			rvalid_q <= pop;
		end
	end

	assign rdata = rdata_q;
	assign rvalid = rvalid_q;
	assign empty = (cnt_q == '0);
	assign level = cnt_q;

endmodule

### sv/rci_back.sv
// Back end: discriminant, pipelined square root and dividers, hit tests and hit packing.
// Depends on rci_pkg; takes jobs from rci_fifo.
module rci_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  rci_pkg::job_t job,
	input  rci_pkg::cfg_t cfg,
	output logic          done,
	output rci_pkg::hit_t result
);
	import rci_pkg::*;

	typedef struct packed {
		job_t                       job;
		logic [MAG_W-1:0]           bl2, blh, bh2, pll, plh, phl, phh;
		logic [SQ_W-1:0]            bsq, ac, sqn;
		logic                       side_en;
		sq_st_t                     sq;
		logic [W-1:0]               cden;
		logic [1:0][W:0]            cdiff;
		logic [1:0]                 cneg, covf, cin, chit, cxn, czn;
		logic [1:0][NUM_W-1:0]      cnum;
		div_st_t [1:0]              cdv;
		logic [1:0][W-1:0]          ct;
		logic [1:0][TP_W-1:0]       cpx, cpz;
		logic [1:0][PT_W-1:0]       cx, cz;
		logic [1:0][FRAC_BITS:0]    cmx, cmz;
		logic [1:0][SV_W-1:0]       sv;
		logic [1:0]                 sneg, sovf, shit, spn;
		logic [1:0][NUM_W-1:0]      snum;
		div_st_t [1:0]              sdv;
		logic [1:0][W-1:0]          st;
		logic [1:0][TP_W-1:0]       sp;
		logic [1:0][PT_W:0]         sy;
	} ctx_t;

	logic [BACK_LAT-1:0] vld_s;
	ctx_t c_s1, c_s2, c_s3, c_s4, c_s5, c_s6, c_s7, c_s8, c_s9, c_s10, c_s11;
	ctx_t qs_s [ROOT_W];
	ctx_t ds_s [QW];
	hit_t res_q;
	logic [MAG_W-1:0] nbv;
	logic [3:0]       hv;
	logic [3:0][W-1:0] hval;
	logic [3:0][W-1:0] slot;
	logic [2:0]       n;
	logic [W:0]       blo_x, bhi_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			done <= 1'b0;
		end else begin
			vld_s <= {vld_s[BACK_LAT-2:0], in_valid};
			done <= vld_s[BACK_LAT-1];
		end
	end

	assign blo_x = {cfg.bound_low[W-1], cfg.bound_low};
	assign bhi_x = {cfg.bound_high[W-1], cfg.bound_high};

	// partial products, cap numerators
	always_ff @(posedge clk) begin
		ctx_t nx;
		nx = '0;
		nx.job = job;
		nx.bl2 = MAG_W'(job.bm[W-1:0]) * MAG_W'(job.bm[W-1:0]);
		nx.blh = MAG_W'(job.bm[W-1:0]) * MAG_W'(job.bm[MAG_W-1:W]);
		nx.bh2 = MAG_W'(job.bm[MAG_W-1:W]) * MAG_W'(job.bm[MAG_W-1:W]);
		nx.pll = MAG_W'(job.am[W-1:0]) * MAG_W'(job.cm[W-1:0]);
		nx.plh = MAG_W'(job.am[W-1:0]) * MAG_W'(job.cm[MAG_W-1:W]);
		nx.phl = MAG_W'(job.am[MAG_W-1:W]) * MAG_W'(job.cm[W-1:0]);
		nx.phh = MAG_W'(job.am[MAG_W-1:W]) * MAG_W'(job.cm[MAG_W-1:W]);
		nx.cden = mag32(job.ray.dir_y);
		nx.cdiff[0] = blo_x - {job.ray.origin_y[W-1], job.ray.origin_y};
		nx.cdiff[1] = bhi_x - {job.ray.origin_y[W-1], job.ray.origin_y};
		c_s1 <= nx;
	end

	always_ff @(posedge clk) begin
		ctx_t nx;
		nx = c_s1;
		nx.bsq = (SQ_W'(c_s1.bh2) << MAG_W) + (SQ_W'(c_s1.blh) << (W + 1)) +
			SQ_W'(c_s1.bl2);
		nx.ac = (SQ_W'(c_s1.phh) << MAG_W) +
			((SQ_W'(c_s1.plh) + SQ_W'(c_s1.phl)) << W) + SQ_W'(c_s1.pll);
		for (int k = 0; k < 2; k++) begin
			nx.cneg[k] = c_s1.cdiff[k][W] ^ c_s1.job.ray.dir_y[W-1];
			nx.cnum[k] = NUM_W'(c_s1.cdiff[k][W] ? (W+1)'((W+1)'(0) - c_s1.cdiff[k]) :
				c_s1.cdiff[k]) << FRAC_BITS;
		end
		c_s2 <= nx;
	end

	// discriminant, cap division setup
	always_ff @(posedge clk) begin
		ctx_t nx;
		nx = c_s2;
		nx.sq = '0;
		if (c_s2.job.c_neg) begin
			nx.sqn = c_s2.bsq + c_s2.ac;
			nx.side_en = c_s2.job.a_ok;
		end else begin
			nx.sqn = c_s2.bsq - c_s2.ac;
			nx.side_en = c_s2.job.a_ok && (c_s2.bsq >= c_s2.ac);
		end
		for (int k = 0; k < 2; k++) begin
			nx.covf[k] = (c_s2.cnum[k] >> QW) >= NUM_W'(c_s2.cden);
			nx.cdv[k].rem = MAG_W'(c_s2.cnum[k] >> QW);
			nx.cdv[k].q = '0;
		end
		c_s3 <= nx;
	end

	// square root, one digit per stage; cap divisions ride along
	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		ctx_t prev;
		if (i == 0) begin : g_first
			assign prev = c_s3;
		end else begin : g_next
			assign prev = qs_s[i-1];
		end
		if (i < QW) begin : g_cdiv
			always_ff @(posedge clk) begin
				ctx_t nx;
				nx = prev;
				nx.sq = sqrt_step(prev.sq, prev.sqn[SQ_W-1-2*i -: 2]);
				for (int k = 0; k < 2; k++) begin
					nx.cdv[k] = div_step(prev.cdv[k], MAG_W'(prev.cden),
						prev.cnum[k][QW-1-i]);
				end
				qs_s[i] <= nx;
			end
		end else begin : g_root
			always_ff @(posedge clk) begin
				ctx_t nx;
				nx = prev;
				nx.sq = sqrt_step(prev.sq, prev.sqn[SQ_W-1-2*i -: 2]);
				qs_s[i] <= nx;
			end
		end
	end

	assign nbv = qs_s[ROOT_W-1].job.bm;

	// side numerators, cap t
	always_ff @(posedge clk) begin
		ctx_t nx;
		nx = qs_s[ROOT_W-1];
		if (qs_s[ROOT_W-1].job.b_neg) begin
			nx.sv[0] = SV_W'(nbv) - SV_W'(qs_s[ROOT_W-1].sq.root);
			nx.sv[1] = SV_W'(nbv) + SV_W'(qs_s[ROOT_W-1].sq.root);
		end else begin
			nx.sv[0] = SV_W'(0) - SV_W'(nbv) - SV_W'(qs_s[ROOT_W-1].sq.root);
			nx.sv[1] = SV_W'(0) - SV_W'(nbv) + SV_W'(qs_s[ROOT_W-1].sq.root);
		end
		for (int k = 0; k < 2; k++) begin
			nx.ct[k] = sat_q(qs_s[ROOT_W-1].cneg[k], qs_s[ROOT_W-1].covf[k],
				qs_s[ROOT_W-1].cdv[k].q);
		end
		c_s4 <= nx;
	end

	always_ff @(posedge clk) begin
		ctx_t nx;
		nx = c_s4;
		for (int k = 0; k < 2; k++) begin
			nx.sneg[k] = c_s4.sv[k][SV_W-1];
			nx.snum[k] = NUM_W'(c_s4.sv[k][SV_W-1] ? SV_W'(SV_W'(0) - c_s4.sv[k]) :
				c_s4.sv[k]) << FRAC_BITS;
			nx.cpx[k] = TP_W'(mag32(c_s4.ct[k])) * TP_W'(mag32(c_s4.job.ray.dir_x));
			nx.cpz[k] = TP_W'(mag32(c_s4.ct[k])) * TP_W'(mag32(c_s4.job.ray.dir_z));
			nx.cxn[k] = c_s4.ct[k][W-1] ^ c_s4.job.ray.dir_x[W-1];
			nx.czn[k] = c_s4.ct[k][W-1] ^ c_s4.job.ray.dir_z[W-1];
		end
		c_s5 <= nx;
	end

	always_ff @(posedge clk) begin
		ctx_t nx;
		nx = c_s5;
		for (int k = 0; k < 2; k++) begin
			nx.sovf[k] = (c_s5.snum[k] >> QW) >= NUM_W'(c_s5.job.am);
			nx.sdv[k].rem = MAG_W'(c_s5.snum[k] >> QW);
			nx.sdv[k].q = '0;
			nx.cx[k] = {{(PT_W-W){c_s5.job.ray.origin_x[W-1]}}, c_s5.job.ray.origin_x} +
				(c_s5.cxn[k] ? PT_W'(PT_W'(0) - PT_W'(c_s5.cpx[k] >> FRAC_BITS)) :
				PT_W'(c_s5.cpx[k] >> FRAC_BITS));
			nx.cz[k] = {{(PT_W-W){c_s5.job.ray.origin_z[W-1]}}, c_s5.job.ray.origin_z} +
				(c_s5.czn[k] ? PT_W'(PT_W'(0) - PT_W'(c_s5.cpz[k] >> FRAC_BITS)) :
				PT_W'(c_s5.cpz[k] >> FRAC_BITS));
		end
		c_s6 <= nx;
	end

	always_ff @(posedge clk) begin
		logic [PT_W-1:0] ax, az;
		ctx_t nx;
		nx = c_s6;
		for (int k = 0; k < 2; k++) begin
			ax = c_s6.cx[k][PT_W-1] ? PT_W'(PT_W'(0) - c_s6.cx[k]) : c_s6.cx[k];
			az = c_s6.cz[k][PT_W-1] ? PT_W'(PT_W'(0) - c_s6.cz[k]) : c_s6.cz[k];
			nx.cin[k] = (ax <= (PT_W'(1) << FRAC_BITS)) &&
				(az <= (PT_W'(1) << FRAC_BITS));
			nx.cmx[k] = ax[FRAC_BITS:0];
			nx.cmz[k] = az[FRAC_BITS:0];
		end
		c_s7 <= nx;
	end

	// side divisions, one quotient bit per stage
	for (genvar i = 0; i < QW; i++) begin : g_div
		ctx_t prev;
		if (i == 0) begin : g_first
			assign prev = c_s7;
		end else begin : g_next
			assign prev = ds_s[i-1];
		end
		always_ff @(posedge clk) begin
			ctx_t nx;
			nx = prev;
			for (int k = 0; k < 2; k++) begin
				nx.sdv[k] = div_step(prev.sdv[k], prev.job.am, prev.snum[k][QW-1-i]);
			end
			ds_s[i] <= nx;
		end
	end

	always_ff @(posedge clk) begin
		ctx_t nx;
		nx = ds_s[QW-1];
		for (int k = 0; k < 2; k++) begin
			nx.st[k] = sat_q(ds_s[QW-1].sneg[k], ds_s[QW-1].sovf[k], ds_s[QW-1].sdv[k].q);
			nx.chit[k] = ds_s[QW-1].job.cap_en && ds_s[QW-1].cin[k] &&
				(SQR_W'(ds_s[QW-1].cmx[k]) * SQR_W'(ds_s[QW-1].cmx[k]) +
				SQR_W'(ds_s[QW-1].cmz[k]) * SQR_W'(ds_s[QW-1].cmz[k]) <=
				(SQR_W'(1) << (2 * FRAC_BITS)));
		end
		c_s8 <= nx;
	end

	always_ff @(posedge clk) begin
		ctx_t nx;
		nx = c_s8;
		for (int k = 0; k < 2; k++) begin
			nx.sp[k] = TP_W'(mag32(c_s8.st[k])) * TP_W'(mag32(c_s8.job.ray.dir_y));
			nx.spn[k] = c_s8.st[k][W-1] ^ c_s8.job.ray.dir_y[W-1];
		end
		c_s9 <= nx;
	end

	always_ff @(posedge clk) begin
		ctx_t nx;
		nx = c_s9;
		for (int k = 0; k < 2; k++) begin
			nx.sy[k] = {{(PT_W+1-W){c_s9.job.ray.origin_y[W-1]}}, c_s9.job.ray.origin_y} +
				(c_s9.spn[k] ? (PT_W+1)'((PT_W+1)'(0) - (PT_W+1)'(c_s9.sp[k] >> FRAC_BITS)) :
				(PT_W+1)'(c_s9.sp[k] >> FRAC_BITS));
		end
		c_s10 <= nx;
	end

	always_ff @(posedge clk) begin
		ctx_t nx;
		nx = c_s10;
		for (int k = 0; k < 2; k++) begin
			nx.shit[k] = c_s10.side_en &&
				($signed({{(PT_W+1-W){cfg.bound_low[W-1]}}, cfg.bound_low}) <
				$signed(c_s10.sy[k])) &&
				($signed(c_s10.sy[k]) <
				$signed({{(PT_W+1-W){cfg.bound_high[W-1]}}, cfg.bound_high}));
		end
		c_s11 <= nx;
	end

	// dense packing: low cap, high cap, near side, far side
	always_comb begin
		hv = {c_s11.shit[1], c_s11.shit[0], c_s11.chit[1], c_s11.chit[0]};
		hval = {c_s11.st[1], c_s11.st[0], c_s11.ct[1], c_s11.ct[0]};
		slot = '0;
		n = '0;
		for (int j = 0; j < 4; j++) begin
			if (hv[j]) begin
				slot[n[1:0]] = hval[j];
				n = n + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q.hit_count <= n;
		res_q.hit_first <= slot[0];
		res_q.hit_second <= slot[1];
		res_q.hit_third <= slot[2];
		res_q.hit_fourth <= slot[3];
	end

	assign result = res_q;

endmodule

### sv/ray_cylinder_intersect.sv
// Top level of the ray / capped unit cylinder intersection block.
// Depends on rci_pkg, rci_front, rci_fifo and rci_back.
//
// One ray is taken per clock while busy is low; in steady streaming busy stays low.
// Each ray gives one result, shown on result for one cycle with done high, after it
// passes 4 front stages, the job queue (write, registered read), 3 setup stages, a
// 64-stage square root (one root bit per stage), 4 stages, a 33-stage divider (one
// quotient bit per stage), 4 test stages and the output register. Results cannot be
// held off; busy rises only when the job queue is at least half full. Configure only
// while idle.
module ray_cylinder_intersect (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  rci_pkg::ray_t               ray,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rci_pkg::CFG_AW-1:0]  cfg_index,
	input  logic [rci_pkg::W-1:0]       cfg_data,
	output logic                        done,
	output rci_pkg::hit_t               result
);
	import rci_pkg::*;

	cfg_t             cfg_q;
	logic             take, push, pop, empty, rvalid;
	job_t             job_in, job_out;
	logic [FIFO_AW:0] level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bound_low <= {1'b1, {(W-1){1'b0}}};
			cfg_q.bound_high <= {1'b0, {(W-1){1'b1}}};
			cfg_q.capped <= 1'b0;
			cfg_q.tol <= TOL_W'(7);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_BOUND_LOW: cfg_q.bound_low <= cfg_data;
				REG_BOUND_HIGH: cfg_q.bound_high <= cfg_data;
				REG_CAPPED: cfg_q.capped <= cfg_data[0];
				REG_TOL: cfg_q.tol <= cfg_data[TOL_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign busy = (level >= (FIFO_AW+1)'(FIFO_DEPTH - FRONT_STAGES));
	assign take = start && !busy;
	assign pop = !empty;

	rci_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (take),
		.ray   (ray),
		.cfg   (cfg_q),
		.push  (push),
		.job   (job_in)
	);

	rci_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (job_in),
		.pop   (pop),
		.rdata (job_out),
		.rvalid(rvalid),
		.empty (empty),
		.level (level)
	);

	rci_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(rvalid),
		.job     (job_out),
		.cfg     (cfg_q),
		.done    (done),
		.result  (result)
	);

endmodule

### tb/ray_cylinder_intersect_tb.sv
// Self-checking testbench for ray_cylinder_intersect: directed and random rays under several
// register settings, each result checked against an in-bench intersection predictor.
// Depends on rci_pkg and the ray_cylinder_intersect RTL.
module ray_cylinder_intersect_tb;
	import rci_pkg::*;

	localparam int DRAIN_CYCLES = 140;
	localparam longint ONE = 64'sd65536;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	ray_t ray;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_AW-1:0] cfg_index;
	logic [W-1:0] cfg_data;
	logic done;
	hit_t result;

	longint bnd_lo, bnd_hi;
	bit cap_on;
	logic [15:0] tol;

	hit_t pending_hits[$];
	int fail_cnt, ray_cnt, hit_rays, burst_left;

	ray_cylinder_intersect dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .ray(ray),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .result(result)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20 * 600000);
		$display("Verification failed");
		$finish;
	end

	function automatic logic [63:0] mag64(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic bit is_small(logic [63:0] m, int sh);
		return m == 0 || m < (64'(tol) << sh);
	endfunction

	// (num << FRAC_BITS) / den toward zero, clamped to 32 bits
	function automatic longint div_sat(bit neg, logic [129:0] m, logic [63:0] den);
		logic [149:0] q;
		q = {4'b0, m, 16'b0} / {86'b0, den};
		if (!neg) return (q > 150'h7FFFFFFF) ? 64'sh7FFFFFFF : longint'(q[31:0]);
		return (q > 150'h80000000) ? -64'sh80000000 : -longint'(q[32:0]);
	endfunction

	function automatic longint mul_trunc(longint t, longint d);
		longint p;
		logic [63:0] m;
		p = t * d;
		m = mag64(p) >> FRAC_BITS;
		return p < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic bit cap_hit(longint t, longint ox, longint oz, longint dx, longint dz);
		logic [63:0] mx, mz;
		mx = mag64(ox + mul_trunc(t, dx));
		mz = mag64(oz + mul_trunc(t, dz));
		if (mx > ONE || mz > ONE) return 0;
		return mx * mx + mz * mz <= 64'(ONE * ONE);
	endfunction

	function automatic logic [63:0] isqrt128(logic [127:0] v);
		logic [63:0] r, cand;
		r = 0;
		for (int i = 63; i >= 0; i--) begin
			cand = r | (64'd1 << i);
			if ({64'b0, cand} * {64'b0, cand} <= v) r = cand;
		end
		return r;
	endfunction

	function automatic hit_t predict_hits(ray_t r);
		longint ox, oy, oz, dx, dy, dz, diff, t, y;
		longint found[4];
		int n;
		logic [63:0] a, bm, cm, s;
		logic signed [66:0] b, c;
		logic signed [131:0] num;
		logic [127:0] bsq, ac, disc;
		bit ok;
		hit_t h;
		ox = r.origin_x; oy = r.origin_y; oz = r.origin_z;
		dx = r.dir_x; dy = r.dir_y; dz = r.dir_z;
		n = 0;
		if (cap_on && !is_small(mag64(dy), 0)) begin
			for (int k = 0; k < 2; k++) begin
				diff = (k == 0 ? bnd_lo : bnd_hi) - oy;
				t = div_sat((diff < 0) != (dy < 0) && diff != 0, 130'(mag64(diff)), mag64(dy));
				if (cap_hit(t, ox, oz, dx, dz)) begin
					found[n] = t;
					n++;
				end
			end
		end
		a = 64'(dx * dx) + 64'(dz * dz);
		if (!is_small(a, FRAC_BITS)) begin
			b = 67'(dx * dx * 0) + 67'(ox * dx) + 67'(oz * dz);
			c = 67'(ox * ox) + 67'(oz * oz) - 67'sd4294967296;
			bm = b < 0 ? 64'(-b) : 64'(b);
			cm = c < 0 ? 64'(-c) : 64'(c);
			bsq = {64'b0, bm} * {64'b0, bm};
			ac = {64'b0, a} * {64'b0, cm};
			ok = 1;
			if (c < 0) disc = bsq + ac;
			else if (bsq < ac) ok = 0;
			else disc = bsq - ac;
			if (ok) begin
				s = isqrt128(disc);
				for (int k = 0; k < 2; k++) begin
					num = -132'(b) + (k == 0 ? -$signed({68'b0, s}) : $signed({68'b0, s}));
					t = div_sat(num < 0, num < 0 ? 130'(-num) : 130'(num), a);
					y = oy + mul_trunc(t, dy);
					if (bnd_lo < y && y < bnd_hi) begin
						found[n] = t;
						n++;
					end
				end
			end
		end
		h = '0;
		h.hit_count = 3'(n);
		if (n > 0) h.hit_first = found[0][31:0];
		if (n > 1) h.hit_second = found[1][31:0];
		if (n > 2) h.hit_third = found[2][31:0];
		if (n > 3) h.hit_fourth = found[3][31:0];
		return h;
	endfunction

	always @(posedge clk) begin
		hit_t e;
		if (arst_n && done) begin
			if (pending_hits.size() == 0) begin
				$error("result beat with nothing pending");
				fail_cnt++;
			end else begin
				e = pending_hits.pop_front();
				if (e.hit_count != 0) hit_rays++;
				if (result.hit_count !== e.hit_count) begin
					$error("hit_count exp %0d got %0d", e.hit_count, result.hit_count);
					fail_cnt++;
				end
				if (result.hit_first !== e.hit_first) begin
					$error("hit_first exp %h got %h", e.hit_first, result.hit_first);
					fail_cnt++;
				end
				if (result.hit_second !== e.hit_second) begin
					$error("hit_second exp %h got %h", e.hit_second, result.hit_second);
					fail_cnt++;
				end
				if (result.hit_third !== e.hit_third) begin
					$error("hit_third exp %h got %h", e.hit_third, result.hit_third);
					fail_cnt++;
				end
				if (result.hit_fourth !== e.hit_fourth) begin
					$error("hit_fourth exp %h got %h", e.hit_fourth, result.hit_fourth);
					fail_cnt++;
				end
			end
		end
	end

	task automatic send_ray(ray_t r);
		start <= 1'b1;
		ray <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_hits.push_back(predict_hits(r));
		ray_cnt++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
				$urandom_range(0, 6);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after the last beat
	task automatic write_reg(cfg_reg_t idx, logic [W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_BOUND_LOW: bnd_lo = longint'(signed'(v));
			REG_BOUND_HIGH: bnd_hi = longint'(signed'(v));
			REG_CAPPED: cap_on = v[0];
			REG_TOL: tol = v[15:0];
			default: ;
		endcase
	endtask

	task automatic set_config(longint lo, longint hi, bit cap, logic [15:0] t);
		wait_idle();
		write_reg(REG_BOUND_LOW, lo[31:0]);
		write_reg(REG_BOUND_HIGH, hi[31:0]);
		write_reg(REG_CAPPED, {$urandom_range(0, 1) ? 31'($urandom) : 31'd0, cap});
		write_reg(REG_TOL, {$urandom_range(0, 1) ? 16'($urandom) : 16'd0, t});
		cfg_valid <= 1'b0;
	endtask

	function automatic ray_t mk_ray(longint ox, longint oy, longint oz,
			longint dx, longint dy, longint dz);
		ray_t r;
		r.origin_x = ox[31:0]; r.origin_y = oy[31:0]; r.origin_z = oz[31:0];
		r.dir_x = dx[31:0]; r.dir_y = dy[31:0]; r.dir_z = dz[31:0];
		return r;
	endfunction

	function automatic longint near_val(int span);
		return longint'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic ray_t rand_ray();
		int mode;
		ray_t r;
		mode = $urandom_range(0, 9);
		if (mode < 2) begin
			r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		end else if (mode < 8) begin
			r = mk_ray(near_val(4 << 16), near_val(4 << 16), near_val(4 << 16),
				near_val(2 << 16), near_val(2 << 16), near_val(2 << 16));
		end else begin
			// nearly axial, small xz direction
			r = mk_ray(near_val(1 << 16), near_val(6 << 16), near_val(1 << 16),
				near_val(300), near_val(2 << 16), near_val(300));
		end
		return r;
	endfunction

	task automatic test_extremes();
		send_ray('0);
		send_ray({6{32'h7FFFFFFF}});
		send_ray({6{32'h80000000}});
		send_ray(mk_ray(-64'sd2147483648, 2147483647, -64'sd2147483648, 2147483647, 1,
			-64'sd2147483648));
		send_ray(mk_ray(-5 * ONE, 0, 0, ONE, 0, 0));
		send_ray(mk_ray(-5 * ONE, ONE / 2, ONE, ONE, 0, 0));
	endtask

	task automatic test_caps();
		set_config(-ONE, ONE, 1, 7);
		send_ray(mk_ray(0, -5 * ONE, 0, 0, ONE, 0));
		send_ray(mk_ray(0, 5 * ONE, 0, 0, -ONE, 0));
		send_ray(mk_ray(ONE / 2, -3 * ONE, 0, 0, ONE, 0));
		send_ray(mk_ray(-3 * ONE, -3 * ONE, 0, ONE, ONE, 0));
		send_ray(mk_ray(0, -5 * ONE, 0, 0, 6, 0));
		send_ray(mk_ray(0, -5 * ONE, 0, 0, 7, 0));
		send_ray(mk_ray(0, 0, 0, 0, 9, 0));
		send_ray(mk_ray(-5 * ONE, 0, 0, ONE, ONE / 8, 0));
	endtask

	task automatic test_inverted_bounds();
		set_config(ONE, -ONE, 1, 0);
		send_ray(mk_ray(-5 * ONE, 0, 0, ONE, 0, 0));
		send_ray(mk_ray(0, -5 * ONE, 0, 0, ONE, 0));
		send_ray(mk_ray(0, 0, 0, 1, 1, 0));
		set_config(ONE, ONE, 1, 65535);
		send_ray(mk_ray(-5 * ONE, ONE, 0, ONE, 0, 0));
		send_ray(mk_ray(0, -5 * ONE, 0, 0, 65535, 0));
		send_ray(mk_ray(0, -5 * ONE, 0, 0, 65536, 0));
		send_ray(mk_ray(-5 * ONE, 0, 0, 255, 0, 0));
		send_ray(mk_ray(-5 * ONE, 0, 0, 256, 0, 0));
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_config(-64'sd2147483648, 2147483647, 0, 7);
				1: set_config(-64'sd2147483648, 2147483647, 1, 0);
				2: set_config(-ONE, ONE, 1, 7);
				3: set_config(near_val(3 << 16), near_val(3 << 16), 1, 16'($urandom));
				4: set_config(-2 * ONE, 3 * ONE, 1, 65535);
				default: set_config(near_val(2 << 16) - 2 * ONE, near_val(2 << 16) + 2 * ONE,
					$urandom_range(0, 1), 16'($urandom_range(0, 64)));
			endcase
			repeat (100) send_ray(rand_ray());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		ray = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		bnd_lo = -64'sh80000000;
		bnd_hi = 64'sh7FFFFFFF;
		cap_on = 0;
		tol = 16'd7;
		burst_left = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_caps();
		test_inverted_bounds();
		test_random();
		wait_idle();
		$display("Sent %0d rays over 10 register settings; %0d rays reported hits.",
			ray_cnt, hit_rays);
		if (fail_cnt == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
